### rtl/core/sorted_matrix_staircase_search_assert.svh
// Assertion macros shared by the RTL.
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_ASSERT_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define SMSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/smss_pkg.sv
package smss_pkg;

  localparam int unsigned MaxRows    = 16;
  localparam int unsigned MaxCols    = 16;
  localparam int unsigned StoreDepth = MaxRows * MaxCols;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned TotalW     = AddrW + 1;
  localparam int unsigned CountW     = 5;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegRowCount    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegColumnCount = 2'd1;

  localparam logic ActLoad   = 1'b0;
  localparam logic ActSearch = 1'b1;

  typedef struct packed {
    logic              restart;
    logic [CountW-1:0] rows;
    logic [CountW-1:0] cols;
    logic [TotalW-1:0] total;
  } smss_dims_t;

  typedef struct packed {
    logic                    we;
    logic [AddrW-1:0]        waddr;
    logic signed [DataW-1:0] wdata;
    logic                    re;
    logic [AddrW-1:0]        raddr;
  } smss_mem_req_t;

  typedef struct packed {
    logic              idle;
    logic              walking;
    logic [CountW-1:0] row;
    logic [CountW-1:0] col;
    logic [AddrW-1:0]  load_pos;
  } smss_status_t;

  function automatic logic [CountW-1:0] clamp_count(logic [CountW-1:0] v,
                                                    logic [CountW-1:0] maxv);
    logic [CountW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CountW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

### rtl/core/smss_store.sv
module smss_store
  import smss_pkg::*;
(
  input  logic                    clk_i,
  input  smss_mem_req_t           req_i,
  output logic signed [DataW-1:0] rdata_o
);

  logic signed [DataW-1:0] mem_q [StoreDepth];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/smss_walker.sv
module smss_walker
  import smss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  smss_dims_t              dims_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_action_i,
  input  logic signed [DataW-1:0] in_element_i,
  input  logic signed [DataW-1:0] in_target_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    out_found_o,
  output smss_mem_req_t           mem_req_o,
  input  logic signed [DataW-1:0] mem_rdata_i,
  output smss_status_t            status_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StCheck = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CountW-1:0]       row_q, row_d;
  logic [CountW-1:0]       col_q, col_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic [AddrW-1:0]        pos_q, pos_d;
  logic                    hit_q, hit_d;
  logic signed [DataW-1:0] target_q, target_d;
  logic                    out_valid_q, out_valid_d;
  logic                    found_q, found_d;

  logic                    accept;
  logic [TotalW-1:0]       pos_inc;
  logic [CountW-1:0]       row_inc;
  logic                    out_free;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_inc    = TotalW'(pos_q) + TotalW'(1);
  assign row_inc    = row_q + CountW'(1);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    hit_d       = hit_q;
    target_d    = target_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = pos_q;
    mem_req_o.wdata = in_element_i;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = idx_q;

    if (dims_i.restart) begin
      pos_d = '0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_action_i == ActLoad) begin
            mem_req_o.we = 1'b1;
            if (pos_inc >= dims_i.total) begin
              pos_d = '0;
            end else begin
              pos_d = pos_inc[AddrW-1:0];
            end
          end else begin
            target_d = in_target_i;
            row_d    = '0;
            col_d    = dims_i.cols - CountW'(1);
            idx_d    = AddrW'(dims_i.cols - CountW'(1));
            hit_d    = 1'b0;
            state_d  = StRead;
          end
        end
      end
      StRead: begin
        mem_req_o.re = 1'b1;
        state_d      = StCheck;
      end
      StCheck: begin
        if (mem_rdata_i == target_q) begin
          hit_d   = 1'b1;
          state_d = StDone;
        end else if (mem_rdata_i < target_q) begin
          row_d = row_inc;
          idx_d = idx_q + AddrW'(dims_i.cols);
          if (row_inc >= dims_i.rows) begin
            state_d = StDone;
          end else begin
            state_d = StRead;
          end
        end else begin
          col_d = col_q - CountW'(1);
          idx_d = idx_q - AddrW'(1);
          if (col_q == '0) begin
            state_d = StDone;
          end else begin
            state_d = StRead;
          end
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      row_q       <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      pos_q       <= pos_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    target_q <= target_d;
    found_q  <= found_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = found_q;

  assign status_o.idle     = (state_q == StIdle);
  assign status_o.walking  = (state_q == StRead) || (state_q == StCheck);
  assign status_o.row      = row_q;
  assign status_o.col      = col_q;
  assign status_o.load_pos = pos_q;

endmodule

### rtl/core/sorted_matrix_staircase_search.sv
// Staircase search over a matrix whose rows and columns are sorted ascending.
// Slave stream: tuser is the action (0 load, 1 search); tdata carries the
// element in bits 31:0 and the target in bits 63:32. A load request writes the
// next element in row-major order and gives no result; a search request gives
// one result on the master stream, tdata bit 0 = found.
// The configuration channel writes row_count (index 0) and column_count
// (index 1); a write to either restarts loading at the first element. It is taken
// only while no search is running and no request is offered on the slave stream.
// A search visits k cells, k <= rows + columns - 1, each through a read of the
// matrix memory (StRead) and a compare (StCheck); the result then passes through
// StDone into the output register, and the next request, load or search, is
// taken only once the walker is back in StIdle.
// Reset sets both counts to 16 and the load position to zero; matrix contents
// are undefined until loaded. A stalled result waits in the output register
// while loads are still accepted; a finished search waits for it to drain.
`include "sorted_matrix_staircase_search_assert.svh"

module sorted_matrix_staircase_search
  import smss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // [31:0] element, [63:32] target
  input  logic               s_axis_tuser,  // [0] action
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [0] found, [7:1] zero
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i
);

  logic [CountW-1:0]       row_count_q, row_count_d;
  logic [CountW-1:0]       column_count_q, column_count_d;
  logic                    cfg_write;
  smss_dims_t              dims;
  smss_mem_req_t           mem_req;
  smss_status_t            status;
  logic signed [DataW-1:0] mem_rdata;
  logic                    found;
  logic                    in_ready;

  assign cfg_ready_o = status.idle && !s_axis_tvalid;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    row_count_d    = row_count_q;
    column_count_d = column_count_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        RegRowCount:    row_count_d = cfg_data_i;
        RegColumnCount: column_count_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CountW'(MaxRows);
      column_count_q <= CountW'(MaxCols);
    end else begin
      row_count_q    <= row_count_d;
      column_count_q <= column_count_d;
    end
  end

  assign dims.restart = cfg_write &&
                        (cfg_index_i == RegRowCount || cfg_index_i == RegColumnCount);
  assign dims.rows    = clamp_count(row_count_q, CountW'(MaxRows));
  assign dims.cols    = clamp_count(column_count_q, CountW'(MaxCols));
  assign dims.total   = TotalW'(dims.rows) * TotalW'(dims.cols);

  smss_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  smss_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dims_i       (dims),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (in_ready),
    .in_action_i  (s_axis_tuser),
    .in_element_i (s_axis_tdata[31:0]),
    .in_target_i  (s_axis_tdata[63:32]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_found_o  (found),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .status_o     (status)
  );

  assign s_axis_tready = in_ready;
  assign m_axis_tdata  = {7'd0, found};

  `SMSS_ASSERT(a_walk_in_bounds, clk_i, rst_ni, status.walking |-> (status.row < dims.rows && status.col < dims.cols), "search walked outside the matrix")
  `SMSS_ASSERT(a_search_starts, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready && s_axis_tuser == ActSearch) |=> status.walking, "accepted search did not start a walk")
  `SMSS_ASSERT(a_load_pos_in_range, clk_i, rst_ni, (TotalW'(status.load_pos) < dims.total), "load position beyond matrix in use")
  `SMSS_ASSERT(a_no_cfg_during_walk, clk_i, rst_ni, status.walking |-> !cfg_ready_o, "configuration taken during a search")

endmodule

### tb/staircase_outcome_check.sv
`timescale 1ns / 100ps

module staircase_outcome_check
  import smss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // [31:0] element, [63:32] target
  input  logic               s_axis_tuser,  // [0] action
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [7:0]         m_axis_tdata,  // [0] found, [7:1] zero
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  output int                 mismatches_o,
  output int                 waiting_o
);

  logic signed [DataW-1:0] cells [StoreDepth];
  logic [CountW-1:0]       row_setting;
  logic [CountW-1:0]       column_setting;
  int unsigned             next_cell;
  logic                    found_due [$];
  int                      mismatches = 0;

  function automatic int unsigned in_use(logic [CountW-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  // Start at the top-right corner; step down on a smaller cell, left on a larger one.
  function automatic logic walk_staircase(logic signed [DataW-1:0] goal);
    int rows;
    int cols;
    int r;
    int c;
    logic signed [DataW-1:0] probe;
    rows = in_use(row_setting, MaxRows);
    cols = in_use(column_setting, MaxCols);
    r = 0;
    c = cols - 1;
    while (r < rows && c >= 0) begin
      probe = cells[r * cols + c];
      if (probe == goal) return 1'b1;
      if (probe < goal) r++;
      else c--;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned total;
    logic want;
    if (!rst_ni) begin
      row_setting = CountW'(MaxRows);
      column_setting = CountW'(MaxCols);
      next_cell = 0;
      found_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (found_due.size() == 0) begin
          mismatches++;
          $display("%0t: result tdata=%h arrived with no request waiting",
                   $time, m_axis_tdata);
        end else begin
          want = found_due.pop_front();
          if (m_axis_tdata !== {7'b0, want}) begin
            mismatches++;
            $display("%0t: expected tdata=%h, got tdata=%h",
                     $time, {7'b0, want}, m_axis_tdata);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegRowCount: begin
            row_setting = cfg_data_i;
            next_cell = 0;
          end
          RegColumnCount: begin
            column_setting = cfg_data_i;
            next_cell = 0;
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ActSearch) begin
          found_due.push_back(walk_staircase(s_axis_tdata[63:32]));
        end else begin
          total = in_use(row_setting, MaxRows) * in_use(column_setting, MaxCols);
          if (next_cell >= total) next_cell = 0;
          cells[next_cell] = s_axis_tdata[31:0];
          next_cell++;
          if (next_cell >= total) next_cell = 0;
        end
      end
    end
    mismatches_o <= mismatches;
    waiting_o <= found_due.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import smss_pkg::*;

  localparam int ItemTarget  = 1800;
  localparam int QuietLimit  = 10000;
  localparam int DrainCycles = 80;
  localparam int HoldCycles  = 2000;
  localparam int HoldPhase   = 6;

  localparam logic [CfgIdxW-1:0] RegSpareLow  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHigh = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic [63:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = ActLoad;
  logic               m_axis_tready = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CountW-1:0]  cfg_data_i = '0;
  wire                s_axis_tready;
  wire                m_axis_tvalid;
  wire  [7:0]         m_axis_tdata;
  wire                cfg_ready_o;

  int mismatches;
  int waiting;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  int rows_used = 1;
  int cols_used = 1;
  logic signed [DataW-1:0] grid [MaxRows][MaxCols];

  always #5 clk_i = ~clk_i;

  sorted_matrix_staircase_search dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  staircase_outcome_check outcome_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .mismatches_o(mismatches),
    .waiting_o(waiting)
  );

  // A requested hold keeps the result side blocked so the block backs up.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_request(logic act, logic [31:0] elem, logic [31:0] tgt);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {tgt, elem};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [CountW-1:0] rv, logic [CountW-1:0] cv);
    if ($urandom_range(1)) begin
      write_register(RegRowCount, rv);
      write_register(RegColumnCount, cv);
    end else begin
      write_register(RegColumnCount, cv);
      write_register(RegRowCount, rv);
    end
    cfg_valid_i <= 1'b0;
    rows_used = (rv == 0) ? 1 : ((rv > MaxRows) ? MaxRows : rv);
    cols_used = (cv == 0) ? 1 : ((cv > MaxCols) ? MaxCols : cv);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Each cell is at least its upper and left neighbors, saturating at the top value.
  task automatic load_grid();
    longint start;
    longint level;
    case ($urandom_range(3))
      0: start = -64'sd2147483648;
      1: start = longint'($signed($urandom));
      2: start = 2147483647 - $urandom_range(40);
      default: start = longint'($urandom_range(40)) - 20;
    endcase
    for (int r = 0; r < rows_used; r++) begin
      for (int c = 0; c < cols_used; c++) begin
        if (r == 0 && c == 0) begin
          level = start;
        end else begin
          level = -64'sd4294967296;
          if (r > 0) level = grid[r-1][c];
          if (c > 0 && grid[r][c-1] > level) level = grid[r][c-1];
          level += ($urandom_range(4) == 0) ? longint'($urandom_range(32'h0FFF_FFFF))
                                            : longint'($urandom_range(3));
          if (level > 64'sd2147483647) level = 64'sd2147483647;
        end
        grid[r][c] = level[31:0];
        send_request(ActLoad, level[31:0], $urandom);
      end
    end
  endtask

  function automatic logic [31:0] pick_target();
    logic [31:0] hit;
    hit = grid[$urandom_range(rows_used - 1)][$urandom_range(cols_used - 1)];
    case ($urandom_range(9))
      5: return hit + 1;
      6: return hit - 1;
      7: return 32'h8000_0000;
      8: return 32'h7FFF_FFFF;
      9: return $urandom;
      default: return hit;
    endcase
  endfunction

  function automatic logic [CountW-1:0] pick_count();
    case ($urandom_range(9))
      0: return '0;
      1: return CountW'(16);
      2: return CountW'($urandom_range(17, 31));
      default: return CountW'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    int phase;
    int mode;
    int searches;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A single cell at both extremes, then overwritten after the load position wraps.
    set_dims('0, '0);
    send_request(ActLoad, 32'h8000_0000, $urandom);
    send_request(ActSearch, $urandom, 32'h8000_0000);
    send_request(ActSearch, $urandom, 32'h7FFF_FFFF);
    send_request(ActSearch, $urandom, 32'h0000_0000);
    send_request(ActLoad, 32'h7FFF_FFFF, $urandom);
    send_request(ActSearch, $urandom, 32'h7FFF_FFFF);
    wait_idle();

    // Writes to unused register indexes must not restart loading.
    set_dims(CountW'(2), CountW'(3));
    send_request(ActLoad, -32'sd5, $urandom);
    send_request(ActLoad, -32'sd2, $urandom);
    send_request(ActLoad, 32'sd4, $urandom);
    wait_idle();
    write_register(RegSpareLow, CountW'($urandom));
    write_register(RegSpareHigh, CountW'($urandom));
    cfg_valid_i <= 1'b0;
    send_request(ActLoad, -32'sd3, $urandom);
    send_request(ActLoad, 32'sd0, $urandom);
    send_request(ActLoad, 32'sd9, $urandom);
    send_request(ActSearch, $urandom, 32'sd9);
    send_request(ActSearch, $urandom, -32'sd3);
    send_request(ActSearch, $urandom, 32'sd1);
    send_request(ActSearch, $urandom, -32'sd6);
    send_request(ActSearch, $urandom, 32'sd10);
    wait_idle();

    items_sent = 0;
    phase = 0;
    while (items_sent < ItemTarget) begin
      mode = (phase < 8) ? phase % 4 : $urandom_range(3);
      case (mode)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 81;
          receiver_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct <= 81;
        end
        default: begin
          sender_idle_pct = 21;
          receiver_stall_pct <= 21;
        end
      endcase
      set_dims(pick_count(), pick_count());
      if (phase != HoldPhase && $urandom_range(7) == 0) begin
        // A random load that may stop short; the next setting reloads from the start.
        repeat ($urandom_range(1, rows_used * cols_used)) begin
          send_request(ActLoad, $urandom, $urandom);
        end
      end else begin
        load_grid();
        if (phase == HoldPhase) hold_requests <= hold_requests + 1;
        searches = (phase == HoldPhase) ? 24 : $urandom_range(4, 16);
        repeat (searches) begin
          if ($urandom_range(9) == 0) send_request(ActLoad, $urandom, $urandom);
          else send_request(ActSearch, $urandom, pick_target());
        end
      end
      wait_idle();
      phase++;
    end

    if (mismatches == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
